[hdl/fifo_queue_indexed_discard_unit_assert.svh]
// Assertion macros for the indexed-discard queue.
`ifndef FIFO_QUEUE_INDEXED_DISCARD_UNIT_ASSERT_SVH
`define FIFO_QUEUE_INDEXED_DISCARD_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FQID_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define FQID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/fqid_pkg.sv]
// Types and codes shared by the indexed-discard queue modules.
package fqid_pkg;

   localparam logic [1:0] OP_ENQ     = 2'd0;
   localparam logic [1:0] OP_DEQ     = 2'd1;
   localparam logic [1:0] OP_DISCARD = 2'd2;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;
   localparam logic [1:0] ERR_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] elem_value;
      logic [3:0]         position;
   } fqid_req_type;

   typedef struct packed {
      logic signed [31:0] head_value;
      logic [4:0]         count;
      logic               is_empty;
      logic [1:0]         error_code;
   } fqid_rsp_type;

endpackage

[hdl/fqid_ram.sv]
// Element store: one write port, one registered read port.
module fqid_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fifo_queue_indexed_discard_unit.sv]
// Bounded queue with enqueue, dequeue and discard by position from the head.
// Enqueue, rejected and ignored items: op, head read and respond, then the strobe.
// Dequeue and discard first shift every later element one place toward the head.
// Each element moved takes a registered store read, then the write;
// busy is high until the strobe cycle, when the next item may be accepted.
// Synchronous reset empties the queue; store contents are not cleared.
`include "fifo_queue_indexed_discard_unit_assert.svh"

module fifo_queue_indexed_discard_unit #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  fqid_pkg::fqid_req_type req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output fqid_pkg::fqid_rsp_type rsp_item
);
   import fqid_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > 4) ? FW : 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_READ_HEAD,
      ST_RESPOND
   } state_type;

   state_type               state_ff, state_in;
   fqid_req_type            req_ff, req_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [1:0]              err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fqid_rsp_type            rsp_item_ff, rsp_item_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [ELEM_WIDTH-1:0]   wr_data;
   logic [AW-1:0]           rd_addr;
   logic [ELEM_WIDTH-1:0]   rd_data;
   logic signed [ELEM_WIDTH-1:0] head_elem;
   logic                    shift_more;

   fqid_ram #(
      .DEPTH(DEPTH),
      .WIDTH(ELEM_WIDTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign head_elem  = signed'(rd_data);
   assign shift_more = (FW'(idx_ff) + FW'(1) < fill_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      err_in       = err_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rd_addr      = idx_ff + AW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               err_in   = ERR_OK;
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            state_in = ST_READ_HEAD;
            unique case (req_ff.req_type)
               OP_ENQ: begin
                  if (fill_ff == FW'(DEPTH)) begin
                     err_in = ERR_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(fill_ff);
                     wr_data = ELEM_WIDTH'(req_ff.elem_value);
                     fill_in = fill_ff + FW'(1);
                  end
               end
               OP_DEQ: begin
                  if (fill_ff == '0) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_SHIFT_RD;
                  end
               end
               OP_DISCARD: begin
                  if (CW'(req_ff.position) >= CW'(fill_ff)) begin
                     err_in = ERR_RANGE;
                  end else begin
                     idx_in   = AW'(req_ff.position);
                     state_in = ST_SHIFT_RD;
                  end
               end
               default: begin
                  state_in = ST_READ_HEAD;
               end
            endcase
         end
         ST_SHIFT_RD: begin
            if (shift_more) begin
               state_in = ST_SHIFT_WR;
            end else begin
               fill_in  = fill_ff - FW'(1);
               state_in = ST_READ_HEAD;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff + AW'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_READ_HEAD: begin
            rd_addr  = '0;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid_in           = 1'b1;
            rsp_item_in.head_value = (fill_ff == '0) ? 32'sd0 : 32'(head_elem);
            rsp_item_in.count      = 5'(fill_ff);
            rsp_item_in.is_empty   = (fill_ff == '0);
            rsp_item_in.error_code = err_ff;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      err_ff      <= err_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `FQID_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FW'(DEPTH), "fill above depth")
   `FQID_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")
   `FQID_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe held")
   `FQID_ASSERT_NOW(a_shift_range, state_ff == ST_SHIFT_WR, shift_more, "shift beyond fill")
   `FQID_ASSERT_NEXT(a_respond_strobe, state_ff == ST_RESPOND, rsp_valid && !busy, "no strobe")

endmodule
